[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define DRD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("drd assertion failed");

// Property checked at every rising clock edge, reset included.
`define DRD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("drd assertion failed");

`endif

[hw/rtl/drd_pkg.sv]
// Shared constants, types and register codes of the detection row decoder.
package drd_pkg;

    // Row layout
    localparam int MAX_CLASSES = 128;
    localparam int BOX_VALUES  = 4;
    localparam int CLASS_LIMIT = 128;  // class index is 7 bits wide
    localparam int COUNT_CAP   = (MAX_CLASSES < CLASS_LIMIT) ? MAX_CLASSES : CLASS_LIMIT;

    // Field widths
    localparam int ELEM_W  = 24;
    localparam int SCORE_W = 16;
    localparam int CLASS_W = 7;
    localparam int IDX_W   = 8;
    localparam int CNT_W   = 8;
    localparam int PAD_W   = 11;
    localparam int SCALE_W = 24;
    localparam int DIM_W   = 14;
    localparam int POS_W   = 13;
    localparam int DIM_MAX = 8192;

    // Corner arithmetic: numerator in 1/512 pixel, product in 2^-25 pixel
    localparam int PAD_SHIFT   = 9;
    localparam int NUM_W       = 27;
    localparam int MAG_W       = 26;
    localparam int PROD_W      = MAG_W + SCALE_W;
    localparam int ROUND_SHIFT = 25;
    localparam int CORNER_W    = 27;

    // Queue between row scanner and corner mapper (depth is a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_LEFT        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_TOP         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd6;

    typedef struct packed {
        logic [CNT_W-1:0]   class_count;
        logic [SCORE_W-1:0] score_threshold;
        logic [PAD_W-1:0]   pad_left;
        logic [PAD_W-1:0]   pad_top;
        logic [SCALE_W-1:0] inverse_scale;
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
    } t_cfg;

    // One detection waiting for its corners to be mapped
    typedef struct packed {
        logic [ELEM_W-1:0]  ctr_x;
        logic [ELEM_W-1:0]  ctr_y;
        logic [ELEM_W-1:0]  width;
        logic [ELEM_W-1:0]  height;
        logic [CLASS_W-1:0] label;
        logic [SCORE_W-1:0] score;
    } t_job;

    // Queue status seen by the row scanner
    typedef struct packed {
        logic full;
    } t_q_status;

endpackage

[hw/rtl/drd_front.sv]
// Row scanner: takes one element per cycle unless the queue is full, keeps box values and best class.
module drd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  drd_pkg::t_cfg                i_cfg,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [drd_pkg::ELEM_W-1:0]   i_element_value,
    input  drd_pkg::t_q_status           i_q_status,
    output logic                         o_push,
    output drd_pkg::t_job                o_job
);
    import drd_pkg::*;

    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [ELEM_W-1:0]  r_cx, r_cy, r_w, r_h;
    logic [SCORE_W-1:0] r_top_score, n_top_score;
    logic [CLASS_W-1:0] r_top_class, n_top_class;

    logic               accept;
    logic               is_box;
    logic [IDX_W-1:0]   cls;
    logic [CNT_W-1:0]   count_eff;
    logic [SCORE_W-1:0] score;
    logic               take_new;
    logic               row_end;

    assign accept  = i_valid && !i_q_status.full;
    assign o_stall = i_q_status.full;

    // Element classification and best-score tracking
    always_comb begin
        if (i_cfg.class_count == '0) begin
            count_eff = CNT_W'(1);
        end else if (i_cfg.class_count > CNT_W'(COUNT_CAP)) begin
            count_eff = CNT_W'(COUNT_CAP);
        end else begin
            count_eff = i_cfg.class_count;
        end

        is_box = r_idx < IDX_W'(BOX_VALUES);
        cls    = r_idx - IDX_W'(BOX_VALUES);

        // scores saturate to unsigned Q0.16
        if (i_element_value[ELEM_W-1]) begin
            score = '0;
        end else if (|i_element_value[ELEM_W-2:SCORE_W]) begin
            score = '1;
        end else begin
            score = i_element_value[SCORE_W-1:0];
        end

        take_new    = (cls == '0) || (score > r_top_score);
        n_top_score = take_new ? score : r_top_score;
        n_top_class = take_new ? cls[CLASS_W-1:0] : r_top_class;

        row_end = !is_box && (({1'b0, cls} + (IDX_W+1)'(1)) >= {1'b0, count_eff});

        if (is_box || !row_end) begin
            n_idx = r_idx + IDX_W'(1);
        end else begin
            n_idx = '0;
        end
    end

    // Detection request into the queue
    assign o_push = accept && row_end && (n_top_score >= i_cfg.score_threshold);

    always_comb begin
        o_job.ctr_x  = r_cx;
        o_job.ctr_y  = r_cy;
        o_job.width  = r_w;
        o_job.height = r_h;
        o_job.label  = n_top_class;
        o_job.score  = n_top_score;
    end

    // Row position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (accept) begin
            r_idx <= n_idx;
        end
    end

    // Box values and running best (always written before they are read)
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (is_box) begin
                case (r_idx[1:0])
                    2'd0:    r_cx <= i_element_value;
                    2'd1:    r_cy <= i_element_value;
                    2'd2:    r_w  <= i_element_value;
                    default: r_h  <= i_element_value;
                endcase
            end else begin
                r_top_score <= n_top_score;
                r_top_class <= n_top_class;
            end
        end
    end

endmodule

[hw/rtl/drd_queue.sv]
// Short request queue between the row scanner and the corner mapper.
module drd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  drd_pkg::t_job       i_job,
    output drd_pkg::t_q_status  o_status,
    output logic                o_valid,
    input  logic                i_pop,
    output drd_pkg::t_job       o_job
);
    import drd_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_status.full = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid       = (r_count != '0);
    assign do_push       = i_push && !o_status.full;
    assign do_pop        = i_pop && o_valid;
    assign o_job         = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

[hw/rtl/drd_back.sv]
// Corner mapper: unpad, scale, round and clamp the four box edges.
module drd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  drd_pkg::t_cfg                 i_cfg,
    input  logic                          i_job_valid,
    input  drd_pkg::t_job                 i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [drd_pkg::CLASS_W-1:0]   o_class_id,
    output logic [drd_pkg::SCORE_W-1:0]   o_confidence,
    output logic [drd_pkg::POS_W-1:0]     o_box_left,
    output logic [drd_pkg::POS_W-1:0]     o_box_top,
    output logic [drd_pkg::DIM_W-1:0]     o_box_width,
    output logic [drd_pkg::DIM_W-1:0]     o_box_height
);
    import drd_pkg::*;

    // corner lanes: left, top, right, bottom
    localparam int LANES   = 4;
    localparam int C_LEFT  = 0;
    localparam int C_TOP   = 1;
    localparam int C_RIGHT = 2;
    localparam int C_BOT   = 3;

    function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] res;
        if (d == '0) begin
            res = DIM_W'(1);
        end else if (d > DIM_W'(DIM_MAX)) begin
            res = DIM_W'(DIM_MAX);
        end else begin
            res = d;
        end
        return res;
    endfunction

    function automatic logic signed [CORNER_W-1:0] clamp(
        input logic signed [CORNER_W-1:0] v,
        input logic signed [CORNER_W-1:0] lo,
        input logic signed [CORNER_W-1:0] hi
    );
        logic signed [CORNER_W-1:0] res;
        if (v < lo) begin
            res = lo;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Stage registers
    logic                       r_s1_valid, r_s2_valid, r_s3_valid, r_o_valid;
    logic [LANES-1:0]           r_s1_neg, r_s2_neg;
    logic [MAG_W-1:0]           r_s1_mag  [LANES];
    logic [PROD_W-1:0]          r_s2_prod [LANES];
    logic signed [CORNER_W-1:0] r_s3_pos  [LANES];
    logic [CLASS_W-1:0]         r_s1_class, r_s2_class, r_s3_class;
    logic [SCORE_W-1:0]         r_s1_score, r_s2_score, r_s3_score;
    logic [CLASS_W-1:0]         r_o_class;
    logic [SCORE_W-1:0]         r_o_score;
    logic [POS_W-1:0]           r_o_left, r_o_top;
    logic [DIM_W-1:0]           r_o_width, r_o_height;

    logic out_ready, s3_ready, s2_ready, s1_ready;

    // Stage advance chain
    assign out_ready = !r_o_valid || !i_stall;
    assign s3_ready  = !r_s3_valid || out_ready;
    assign s2_ready  = !r_s2_valid || s3_ready;
    assign s1_ready  = !r_s1_valid || s2_ready;
    assign o_pop     = i_job_valid && s1_ready;

    // Stage 1 math: numerators 2*c -/+ size - pad*512, as sign and magnitude
    logic signed [NUM_W-1:0] cx_s, cy_s, w_s, h_s, padx_s, pady_s;
    logic signed [NUM_W-1:0] num [LANES];
    logic [LANES-1:0]        n_neg;
    logic [MAG_W-1:0]        n_mag [LANES];
    logic signed [NUM_W-1:0] num_abs;

    always_comb begin
        cx_s   = NUM_W'($signed(i_job.ctr_x));
        cy_s   = NUM_W'($signed(i_job.ctr_y));
        w_s    = NUM_W'($signed(i_job.width));
        h_s    = NUM_W'($signed(i_job.height));
        padx_s = $signed({{(NUM_W-PAD_W-PAD_SHIFT){1'b0}}, i_cfg.pad_left,
                          {PAD_SHIFT{1'b0}}});
        pady_s = $signed({{(NUM_W-PAD_W-PAD_SHIFT){1'b0}}, i_cfg.pad_top,
                          {PAD_SHIFT{1'b0}}});
        num[C_LEFT]  = (cx_s <<< 1) - w_s - padx_s;
        num[C_RIGHT] = (cx_s <<< 1) + w_s - padx_s;
        num[C_TOP]   = (cy_s <<< 1) - h_s - pady_s;
        num[C_BOT]   = (cy_s <<< 1) + h_s - pady_s;
        num_abs      = '0;
        for (int k = 0; k < LANES; k++) begin
            n_neg[k] = num[k][NUM_W-1];
            num_abs  = n_neg[k] ? -num[k] : num[k];
            n_mag[k] = num_abs[MAG_W-1:0];
        end
    end

    // Stage 3 math: round half away from zero, restore sign
    logic [PROD_W-1:0]          rsum [LANES];
    logic signed [CORNER_W-1:0] rmag [LANES];
    logic signed [CORNER_W-1:0] n_pos [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            rsum[k]  = r_s2_prod[k] + (PROD_W'(1) << (ROUND_SHIFT - 1));
            rmag[k]  = $signed(CORNER_W'(rsum[k][PROD_W-1:ROUND_SHIFT]));
            n_pos[k] = r_s2_neg[k] ? -rmag[k] : rmag[k];
        end
    end

    // Output stage math: clamp into the image, at least one pixel
    logic signed [CORNER_W-1:0] wd_s, ht_s, one_s;
    logic signed [CORNER_W-1:0] c_left, c_top, c_right, c_bot;
    logic signed [CORNER_W-1:0] c_wd, c_ht;

    always_comb begin
        one_s   = CORNER_W'(1);
        wd_s    = $signed(CORNER_W'(dim_eff(i_cfg.image_width)));
        ht_s    = $signed(CORNER_W'(dim_eff(i_cfg.image_height)));
        c_left  = clamp(r_s3_pos[C_LEFT], '0, wd_s - one_s);
        c_top   = clamp(r_s3_pos[C_TOP],  '0, ht_s - one_s);
        c_right = clamp(r_s3_pos[C_RIGHT], c_left + one_s, wd_s);
        c_bot   = clamp(r_s3_pos[C_BOT],   c_top + one_s,  ht_s);
        c_wd    = c_right - c_left;
        c_ht    = c_bot - c_top;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_job_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
            if (out_ready) begin
                r_o_valid <= r_s3_valid;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_neg   <= n_neg;
            r_s1_mag   <= n_mag;
            r_s1_class <= i_job.label;
            r_s1_score <= i_job.score;
        end
        if (s2_ready) begin
            for (int k = 0; k < LANES; k++) begin
                r_s2_prod[k] <= PROD_W'(r_s1_mag[k]) * PROD_W'(i_cfg.inverse_scale);
            end
            r_s2_neg   <= r_s1_neg;
            r_s2_class <= r_s1_class;
            r_s2_score <= r_s1_score;
        end
        if (s3_ready) begin
            r_s3_pos   <= n_pos;
            r_s3_class <= r_s2_class;
            r_s3_score <= r_s2_score;
        end
        if (out_ready) begin
            r_o_class  <= r_s3_class;
            r_o_score  <= r_s3_score;
            r_o_left   <= c_left[POS_W-1:0];
            r_o_top    <= c_top[POS_W-1:0];
            r_o_width  <= c_wd[DIM_W-1:0];
            r_o_height <= c_ht[DIM_W-1:0];
        end
    end

    assign o_valid      = r_o_valid;
    assign o_class_id   = r_o_class;
    assign o_confidence = r_o_score;
    assign o_box_left   = r_o_left;
    assign o_box_top    = r_o_top;
    assign o_box_width  = r_o_width;
    assign o_box_height = r_o_height;

endmodule

[hw/rtl/detection_row_decode_top.sv]
// Top level of the detection row decoder: configuration registers and wiring.
//
// Takes one detector output element per cycle; a row is four box values
// followed by class_count scores, and a row whose best score reaches the
// threshold yields one detection. Input is accepted every cycle; the row
// scanner hands detections to a two-entry queue, and the input stalls only
// while that queue is full, which happens only when the output is held off.
// A detection passes the queue, numerator stage, four-lane scale multiply,
// rounding and the clamp into the output register. The mapper accepts a
// detection every cycle while the output is not held off, so with the shortest
// row of five elements it is never the limit. Configuration writes take effect
// at once and are meant to be made between rows or with the block drained.
module detection_row_decode_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [drd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [drd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [drd_pkg::ELEM_W-1:0]       i_element_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [drd_pkg::CLASS_W-1:0]      o_class_id,
    output logic [drd_pkg::SCORE_W-1:0]      o_confidence,
    output logic [drd_pkg::POS_W-1:0]        o_box_left,
    output logic [drd_pkg::POS_W-1:0]        o_box_top,
    output logic [drd_pkg::DIM_W-1:0]        o_box_width,
    output logic [drd_pkg::DIM_W-1:0]        o_box_height
);
    import drd_pkg::*;

    t_cfg      r_cfg;
    t_job      front_job, queue_job;
    t_q_status q_status;
    logic      front_push, queue_valid, back_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.class_count     <= CNT_W'(1);
            r_cfg.score_threshold <= SCORE_W'(16384);
            r_cfg.pad_left        <= '0;
            r_cfg.pad_top         <= '0;
            r_cfg.inverse_scale   <= SCALE_W'(65536);
            r_cfg.image_width     <= DIM_W'(640);
            r_cfg.image_height    <= DIM_W'(640);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CLASS_COUNT:     r_cfg.class_count     <= i_cfg_data[CNT_W-1:0];
                CFG_SCORE_THRESHOLD: r_cfg.score_threshold <= i_cfg_data[SCORE_W-1:0];
                CFG_PAD_LEFT:        r_cfg.pad_left        <= i_cfg_data[PAD_W-1:0];
                CFG_PAD_TOP:         r_cfg.pad_top         <= i_cfg_data[PAD_W-1:0];
                CFG_INVERSE_SCALE:   r_cfg.inverse_scale   <= i_cfg_data[SCALE_W-1:0];
                CFG_IMAGE_WIDTH:     r_cfg.image_width     <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:    r_cfg.image_height    <= i_cfg_data[DIM_W-1:0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    drd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (i_in_valid),
        .o_stall         (o_in_stall),
        .i_element_value (i_element_value),
        .i_q_status      (q_status),
        .o_push          (front_push),
        .o_job           (front_job)
    );

    drd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (front_push),
        .i_job    (front_job),
        .o_status (q_status),
        .o_valid  (queue_valid),
        .i_pop    (back_pop),
        .o_job    (queue_job)
    );

    drd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_job_valid  (queue_valid),
        .i_job        (queue_job),
        .o_pop        (back_pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_class_id   (o_class_id),
        .o_confidence (o_confidence),
        .o_box_left   (o_box_left),
        .o_box_top    (o_box_top),
        .o_box_width  (o_box_width),
        .o_box_height (o_box_height)
    );

endmodule

[hw/rtl/drd_checker.sv]
// Port-level checks of the detection row decoder, bound to its top level.
`include "assert_macros.svh"

module drd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [6:0] i_class_id,
    input  logic [15:0] i_confidence,
    input  logic [12:0] i_box_left,
    input  logic [12:0] i_box_top,
    input  logic [13:0] i_box_width,
    input  logic [13:0] i_box_height
);

    // a held detection stays offered and unchanged
    `DRD_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall |=> i_out_valid)
    `DRD_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && i_out_stall |=> $stable(i_class_id) && $stable(i_confidence) && $stable(i_box_left) && $stable(i_box_top) && $stable(i_box_width) && $stable(i_box_height))

    // boxes are at least one pixel and stay inside the largest image
    `DRD_ASSERT(a_box_nonempty, i_clk, i_rst_n, i_out_valid |-> (i_box_width != 14'd0) && (i_box_height != 14'd0))
    `DRD_ASSERT(a_box_inside, i_clk, i_rst_n, i_out_valid |-> ((15'(i_box_left) + 15'(i_box_width)) <= 15'd8192) && ((15'(i_box_top) + 15'(i_box_height)) <= 15'd8192))

    // reset empties the output
    `DRD_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind detection_row_decode_top drd_checker u_drd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .i_class_id   (o_class_id),
    .i_confidence (o_confidence),
    .i_box_left   (o_box_left),
    .i_box_top    (o_box_top),
    .i_box_width  (o_box_width),
    .i_box_height (o_box_height)
);

[verif/tb_top.sv]
// Self-checking testbench of the detection row decoder: directed and random rows.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import drd_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int DRAIN_CYCLES = 12;   // queue read, numerators, multiply, round, clamp, plus margin

    typedef struct packed {
        logic [CLASS_W-1:0] label;
        logic [SCORE_W-1:0] confidence;
        logic [POS_W-1:0]   box_left;
        logic [POS_W-1:0]   box_top;
        logic [DIM_W-1:0]   box_width;
        logic [DIM_W-1:0]   box_height;
    } t_detection;

    // Row decoder predictor and store of expected detections
    class t_row_scoreboard;
        t_cfg               cfg;
        logic [IDX_W-1:0]   element_index;
        logic [ELEM_W-1:0]  ctr_x, ctr_y, box_w, box_h;
        logic [SCORE_W-1:0] top_score;
        logic [CLASS_W-1:0] top_class;
        t_detection         expected_q[$];
        int                 mismatches;

        function new();
            cfg.class_count     = 8'd1;
            cfg.score_threshold = 16'd16384;
            cfg.pad_left        = '0;
            cfg.pad_top         = '0;
            cfg.inverse_scale   = 24'd65536;
            cfg.image_width     = 14'd640;
            cfg.image_height    = 14'd640;
            element_index = '0;
            ctr_x = '0;
            ctr_y = '0;
            box_w = '0;
            box_h = '0;
            top_score = '0;
            top_class = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CLASS_COUNT:     cfg.class_count     = data[CNT_W-1:0];
                CFG_SCORE_THRESHOLD: cfg.score_threshold = data[SCORE_W-1:0];
                CFG_PAD_LEFT:        cfg.pad_left        = data[PAD_W-1:0];
                CFG_PAD_TOP:         cfg.pad_top         = data[PAD_W-1:0];
                CFG_INVERSE_SCALE:   cfg.inverse_scale   = data[SCALE_W-1:0];
                CFG_IMAGE_WIDTH:     cfg.image_width     = data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:    cfg.image_height    = data[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        // Scores per row after saturation of the count register
        function int row_classes();
            int n;
            n = int'(cfg.class_count);
            if (n == 0) n = 1;
            if (n > COUNT_CAP) n = COUNT_CAP;
            return n;
        endfunction

        // Numerator in 1/512 pixel times Q8.16 scale, rounded half away from zero
        function longint map_corner(longint num);
            longint unsigned mag, r;
            mag = (num < 0) ? -num : num;
            r = (mag * 64'(cfg.inverse_scale) + (64'd1 << 24)) >> 25;
            return (num < 0) ? -longint'(r) : longint'(r);
        endfunction

        function longint clamp_to(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function longint dim_limit(logic [DIM_W-1:0] d);
            if (d == '0) return 1;
            if (int'(d) > DIM_MAX) return DIM_MAX;
            return longint'(d);
        endfunction

        function void note_element(logic [ELEM_W-1:0] raw);
            int                 cls;
            longint             v, cx, cy, w, h, x1, x2, y1, y2, wd, ht, l, t, r, b;
            logic [SCORE_W-1:0] score;
            t_detection         d;
            // Box values first
            if (element_index < BOX_VALUES) begin
                case (element_index)
                    'd0: ctr_x = raw;
                    'd1: ctr_y = raw;
                    'd2: box_w = raw;
                    default: box_h = raw;
                endcase
                element_index++;
                return;
            end
            // Class score: saturate to Q0.16, keep the first maximum
            cls = int'(element_index) - BOX_VALUES;
            v = longint'($signed(raw));
            score = (v < 0) ? '0 : ((v > 65535) ? 16'hFFFF : v[SCORE_W-1:0]);
            if (cls == 0 || score > top_score) begin
                top_score = score;
                top_class = cls[CLASS_W-1:0];
            end
            if (cls + 1 < row_classes()) begin
                element_index++;
                return;
            end
            element_index = '0;
            if (top_score < cfg.score_threshold) return;
            // Map corners back to the original image and clamp
            cx = longint'($signed(ctr_x));
            cy = longint'($signed(ctr_y));
            w  = longint'($signed(box_w));
            h  = longint'($signed(box_h));
            x1 = map_corner(2 * cx - w - longint'(cfg.pad_left) * 512);
            x2 = map_corner(2 * cx + w - longint'(cfg.pad_left) * 512);
            y1 = map_corner(2 * cy - h - longint'(cfg.pad_top) * 512);
            y2 = map_corner(2 * cy + h - longint'(cfg.pad_top) * 512);
            wd = dim_limit(cfg.image_width);
            ht = dim_limit(cfg.image_height);
            l = clamp_to(x1, 0, wd - 1);
            t = clamp_to(y1, 0, ht - 1);
            r = clamp_to(x2, l + 1, wd);
            b = clamp_to(y2, t + 1, ht);
            d.label      = top_class;
            d.confidence = top_score;
            d.box_left   = POS_W'(l);
            d.box_top    = POS_W'(t);
            d.box_width  = DIM_W'(r - l);
            d.box_height = DIM_W'(b - t);
            expected_q.insert(expected_q.size(), d);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_detection(t_detection got);
            t_detection want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("detection class %0d with none expected", got.label));
                return;
            end
            want = expected_q.pop_front();
            if (got.label != want.label)
                report_mismatch($sformatf("class %0d, want %0d", got.label, want.label));
            if (got.confidence != want.confidence)
                report_mismatch($sformatf("confidence %0d, want %0d",
                                          got.confidence, want.confidence));
            if (got.box_left != want.box_left)
                report_mismatch($sformatf("box_left %0d, want %0d", got.box_left, want.box_left));
            if (got.box_top != want.box_top)
                report_mismatch($sformatf("box_top %0d, want %0d", got.box_top, want.box_top));
            if (got.box_width != want.box_width)
                report_mismatch($sformatf("box_width %0d, want %0d",
                                          got.box_width, want.box_width));
            if (got.box_height != want.box_height)
                report_mismatch($sformatf("box_height %0d, want %0d",
                                          got.box_height, want.box_height));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [ELEM_W-1:0]     i_element_value;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [CLASS_W-1:0]    o_class_id;
    logic [SCORE_W-1:0]    o_confidence;
    logic [POS_W-1:0]      o_box_left;
    logic [POS_W-1:0]      o_box_top;
    logic [DIM_W-1:0]      o_box_width;
    logic [DIM_W-1:0]      o_box_height;

    t_row_scoreboard rows = new();
    int sender_idle_pct   = 37;
    int receiver_idle_pct = 85;
    int items_sent        = 0;

    detection_row_decode_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_element_value (i_element_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_class_id      (o_class_id),
        .o_confidence    (o_confidence),
        .o_box_left      (o_box_left),
        .o_box_top       (o_box_top),
        .o_box_width     (o_box_width),
        .o_box_height    (o_box_height)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest correct run
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Output side: random stall, updated at the falling edge
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    // Check each accepted detection
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            rows.check_detection({o_class_id, o_confidence, o_box_left, o_box_top,
                                  o_box_width, o_box_height});
    end

    // One element request, held until accepted
    task automatic send_element(logic [ELEM_W-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_element_value <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        rows.note_element(value);
        items_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        rows.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid, wait for all detections, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (rows.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly boxes inside a typical image, some fully random bit patterns
    function automatic logic [ELEM_W-1:0] box_value(bit is_size);
        if ($urandom_range(99) < 40) return ELEM_W'($urandom());
        if (is_size) return ELEM_W'($urandom_range(0, 300 * 256));
        return ELEM_W'($urandom_range(0, 700 * 256));
    endfunction

    function automatic logic [ELEM_W-1:0] score_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) return {1'b1, 23'($urandom())};
        if (pick < 15) return ELEM_W'($urandom_range(65536, 8388607));
        if (pick < 22) return ELEM_W'(16'hFFFF);
        if (pick < 35) return ELEM_W'(rows.top_score);   // tie with the current best
        return ELEM_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_row();
        send_element(box_value(1'b0));
        send_element(box_value(1'b0));
        send_element(box_value(1'b1));
        send_element(box_value(1'b1));
        do send_element(score_value()); while (rows.element_index != '0);
    endtask

    // Register set per phase: lows, highs, out-of-range values, then random
    task automatic load_config(int phase);
        int cc, thr, pl, pt, inv, iw, ih;
        case (phase)
            0: begin
                cc = 1; thr = 0; pl = 0; pt = 0; inv = 1; iw = 1; ih = 1;
            end
            1: begin
                cc = 128; thr = 65535; pl = 2047; pt = 2047; inv = 24'hFFFFFF;
                iw = DIM_MAX; ih = DIM_MAX;
            end
            2: begin
                cc = 0; thr = 16384; pl = 100; pt = 50; inv = 0; iw = 0; ih = 16383;
            end
            3: begin
                cc = 255; thr = 1000; pl = 10; pt = 20; inv = 65536; iw = 16383; ih = 0;
            end
            default: begin
                case ($urandom_range(0, 19))
                    0: cc = 0;
                    1: cc = 255;
                    2: cc = 128;
                    3: cc = 200;
                    4: cc = $urandom_range(9, 127);
                    default: cc = $urandom_range(1, 8);
                endcase
                case ($urandom_range(0, 9))
                    0: thr = 0;
                    1: thr = 65535;
                    2, 3: thr = $urandom_range(0, 65535);
                    default: thr = $urandom_range(0, 40000);
                endcase
                pl = ($urandom_range(0, 5) == 0) ? 2047 : $urandom_range(0, 200);
                pt = ($urandom_range(0, 5) == 0) ? 2047 : $urandom_range(0, 200);
                case ($urandom_range(0, 9))
                    0: inv = 0;
                    1: inv = 24'hFFFFFF;
                    2: inv = $urandom_range(1, 24'hFFFFFF);
                    default: inv = $urandom_range(32768, 262144);
                endcase
                case ($urandom_range(0, 9))
                    0: iw = $urandom_range(8193, 16383);
                    1: iw = DIM_MAX;
                    default: iw = $urandom_range(64, 2048);
                endcase
                case ($urandom_range(0, 9))
                    0: ih = $urandom_range(8193, 16383);
                    1: ih = DIM_MAX;
                    default: ih = $urandom_range(64, 2048);
                endcase
            end
        endcase
        write_reg(CFG_CLASS_COUNT, CFG_DATA_W'(cc));
        write_reg(CFG_SCORE_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(CFG_PAD_LEFT, CFG_DATA_W'(pl));
        write_reg(CFG_PAD_TOP, CFG_DATA_W'(pt));
        write_reg(CFG_INVERSE_SCALE, CFG_DATA_W'(inv));
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(iw));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(ih));
    endtask

    task automatic directed_rows();
        // Reset registers: box at the signed extremes, score exactly at threshold
        send_element(24'h7FFFFF);
        send_element(24'h800000);
        send_element(24'h000000);
        send_element(24'hFFFFFF);
        send_element(24'd16384);
        // Negative score reads as zero, so no detection
        send_element(24'd25600);
        send_element(24'd25600);
        send_element(24'd12800);
        send_element(24'd10240);
        send_element(24'hFFFFFF);
        // Score above Q0.16 saturates to full scale
        send_element(24'd25600);
        send_element(24'd25600);
        send_element(24'd12800);
        send_element(24'd10240);
        send_element(24'h7FFFFF);
        settle();
        // Zero inverse scale and full padding; the tie keeps the first class
        write_reg(CFG_CLASS_COUNT, 24'd3);
        write_reg(CFG_SCORE_THRESHOLD, 24'd0);
        write_reg(CFG_INVERSE_SCALE, 24'd0);
        write_reg(CFG_PAD_LEFT, 24'd2047);
        write_reg(CFG_PAD_TOP, 24'd2047);
        send_element(24'd51200);
        send_element(24'd40960);
        send_element(24'd2560);
        send_element(24'd5120);
        send_element(24'd100);
        send_element(24'd300);
        send_element(24'd300);
        // Class count lowered mid-row: the next score closes the row
        send_element(24'd1000);
        send_element(24'd2000);
        send_element(24'd3000);
        send_element(24'd4000);
        send_element(24'd7);
        settle();
        write_reg(CFG_CLASS_COUNT, 24'd1);
        send_element(24'd5);
        settle();
    endtask

    initial begin
        int phase, base, done, row_count;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_element_value = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_rows();

        // Random phases; idling mode follows progress through the random items
        base = items_sent;
        phase = 0;
        while (items_sent - base < RANDOM_ITEMS) begin
            done = items_sent - base;
            if (done < RANDOM_ITEMS / 3) begin
                sender_idle_pct = 37;
                receiver_idle_pct = 85;
            end else if (done < 2 * RANDOM_ITEMS / 3) begin
                sender_idle_pct = 85;
                receiver_idle_pct = 37;
            end else begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            load_config(phase);
            row_count = (rows.row_classes() > 16) ? 1 : $urandom_range(4, 12);
            repeat (row_count) send_row();
            settle();
            phase++;
        end

        if (rows.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
